// File: rtl/core/hompl_pkg.sv
// shared types, constants and character decoders for the measurement line parser
`default_nettype none
package hompl_pkg;

	localparam int unsigned POS_W   = 6;
	localparam int unsigned FIELD_W = 28;
	localparam int unsigned EXP_W   = 5;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [POS_W-1:0] POS_TIME_FIRST = 6'd3;
	localparam logic [POS_W-1:0] POS_TIME_LAST  = 6'd9;
	localparam logic [POS_W-1:0] POS_TIME_PFX   = 6'd10;
	localparam logic [POS_W-1:0] POS_VOLT_FIRST = 6'd14;
	localparam logic [POS_W-1:0] POS_VOLT_LAST  = 6'd20;
	localparam logic [POS_W-1:0] POS_VOLT_PFX   = 6'd21;
	localparam logic [POS_W-1:0] POS_CURR_FIRST = 6'd25;
	localparam logic [POS_W-1:0] POS_CURR_LAST  = 6'd31;

	localparam logic [7:0] CHAR_START = 8'h50; // 'P'

	localparam logic [FIELD_W-1:0] MANT_OFFSET = 28'h8000000;

	typedef logic signed [FIELD_W-1:0] mant_t;
	typedef logic signed [EXP_W-1:0]   exp_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_dig_t;

	typedef struct packed {
		logic clear;
		logic take;
	} field_ctl_t;

	function automatic hex_dig_t hex_digit(input logic [7:0] c);
		hex_dig_t d;
		d.ok  = 1'b1;
		d.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			// 'a'..'f' and 'A'..'F' share low bits 1..6
			d.val = 4'(c[2:0] + 3'd1) + 4'd8;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

	function automatic exp_t prefix_code(input logic [7:0] c);
		exp_t e;
		unique case (c)
			8'h6d:   e = -5'sd3;  // m
			8'h75:   e = -5'sd6;  // u
			8'h6e:   e = -5'sd9;  // n
			8'h70:   e = -5'sd12; // p
			8'h66:   e = -5'sd15; // f
			8'h6b:   e = 5'sd3;   // k
			8'h4d:   e = 5'sd6;   // M
			8'h47:   e = 5'sd9;   // G
			default: e = 5'sd0;
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/hompl_ifs.sv
// handshake channels for characters in and parsed lines out
`default_nettype none
interface hompl_char_if
	import hompl_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_of_line;

	modport source (output valid, output char_code, output last_of_line, input ready);
	modport sink   (input valid, input char_code, input last_of_line, output ready);
endinterface

interface hompl_line_if
	import hompl_pkg::*;
();
	logic  valid;
	logic  ready;
	logic  line_ok;
	mant_t time_value;
	exp_t  time_exponent;
	mant_t voltage_value;
	exp_t  voltage_exponent;
	mant_t current_value;

	modport source (output valid, output line_ok, output time_value, output time_exponent,
		output voltage_value, output voltage_exponent, output current_value, input ready);
	modport sink   (input valid, input line_ok, input time_value, input time_exponent,
		input voltage_value, input voltage_exponent, input current_value, output ready);
endinterface
`default_nettype wire

// File: rtl/core/hompl_field_acc.sv
// one hex field accumulator that stops at the first non-hex character
`default_nettype none
module hompl_field_acc
	import hompl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire field_ctl_t         ctl,
	input  wire logic [7:0]         char_code,
	output logic      [FIELD_W-1:0] acc_next
);

	logic [FIELD_W-1:0] acc_q;
	logic               stopped_q;
	logic               stopped_next;
	hex_dig_t           dig;

	always_comb begin
		dig          = hex_digit(char_code);
		acc_next     = acc_q;
		stopped_next = stopped_q;
		if (ctl.take && !stopped_q) begin
			if (dig.ok) begin
				acc_next = {acc_q[FIELD_W-5:0], dig.val};
			end else begin
				stopped_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			stopped_q <= 1'b0;
		end else if (ctl.clear) begin
			acc_q     <= '0;
			stopped_q <= 1'b0;
		end else begin
			acc_q     <= acc_next;
			stopped_q <= stopped_next;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/hex_offset_measurement_line_parser.sv
// top level of the hex offset measurement line parser
// usage:
//   chars   : one character word per handshake, last_of_line marks the line end
//   results : one word per line, sent for the character flagged last_of_line
// a line counts only if its first character is 'P'; otherwise line_ok is 0 and
// every other result field is 0. hex fields sit at positions 3..9, 14..20 and
// 25..31, prefix letters at 10 and 21; mantissas come out as raw hex minus 2^27
// timing:
//   one character is taken every cycle while chars.ready is high; position
//   counter, accumulators and prefix registers all update in the cycle the
//   character is accepted; the result word appears in the output register in
//   the cycle after the last character of its line is accepted
// stall: while the output register holds a word that is not taken, chars.ready
//   is low; it rises again in the cycle the word is taken, so a draining
//   receiver lets a new character in during that same cycle
// reset: arst_n clears the line state and empties the output register
`default_nettype none
module hex_offset_measurement_line_parser
	import hompl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	hompl_char_if.sink   chars,
	hompl_line_if.source results
);

	// line state
	logic [POS_W-1:0] pos_q;
	logic             start_p_q;
	exp_t             time_exp_q;
	exp_t             volt_exp_q;

	// output register
	logic  out_valid_q;
	logic  line_ok_q;
	mant_t time_val_q;
	exp_t  time_exp_out_q;
	mant_t volt_val_q;
	exp_t  volt_exp_out_q;
	mant_t curr_val_q;

	logic             accept;
	logic             line_end;
	logic             start_p_next;
	exp_t             time_exp_next;
	exp_t             volt_exp_next;
	field_ctl_t       ctl_time;
	field_ctl_t       ctl_volt;
	field_ctl_t       ctl_curr;
	logic [FIELD_W-1:0] time_acc;
	logic [FIELD_W-1:0] volt_acc;
	logic [FIELD_W-1:0] curr_acc;

	// room when the output register is empty or is being drained now
	assign chars.ready = !out_valid_q || results.ready;
	assign accept      = chars.valid && chars.ready;
	assign line_end    = accept && chars.last_of_line;

	always_comb begin
		ctl_time.clear = line_end;
		ctl_volt.clear = line_end;
		ctl_curr.clear = line_end;
		ctl_time.take  = accept && pos_q >= POS_TIME_FIRST && pos_q <= POS_TIME_LAST;
		ctl_volt.take  = accept && pos_q >= POS_VOLT_FIRST && pos_q <= POS_VOLT_LAST;
		ctl_curr.take  = accept && pos_q >= POS_CURR_FIRST && pos_q <= POS_CURR_LAST;

		// values including the current character, used for the result word
		start_p_next  = (pos_q == '0) ? (chars.char_code == CHAR_START) : start_p_q;
		time_exp_next = (pos_q == POS_TIME_PFX) ? prefix_code(chars.char_code) : time_exp_q;
		volt_exp_next = (pos_q == POS_VOLT_PFX) ? prefix_code(chars.char_code) : volt_exp_q;
	end

	hompl_field_acc u_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_time),
		.char_code (chars.char_code),
		.acc_next  (time_acc)
	);

	hompl_field_acc u_volt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_volt),
		.char_code (chars.char_code),
		.acc_next  (volt_acc)
	);

	hompl_field_acc u_curr (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_curr),
		.char_code (chars.char_code),
		.acc_next  (curr_acc)
	);

	// position counter, start flag and prefix exponents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			start_p_q  <= 1'b0;
			time_exp_q <= '0;
			volt_exp_q <= '0;
		end else if (line_end) begin
			pos_q      <= '0;
			start_p_q  <= 1'b0;
			time_exp_q <= '0;
			volt_exp_q <= '0;
		end else if (accept) begin
			if (pos_q != POS_MAX) begin
				pos_q <= pos_q + POS_W'(1);
			end
			start_p_q  <= start_p_next;
			time_exp_q <= time_exp_next;
			volt_exp_q <= volt_exp_next;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (line_end) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, zeroed for a line that did not start with 'P'
	always_ff @(posedge clk) begin
		if (line_end) begin
			line_ok_q      <= start_p_next;
			time_val_q     <= start_p_next ? mant_t'(time_acc - MANT_OFFSET) : '0;
			time_exp_out_q <= start_p_next ? time_exp_next : '0;
			volt_val_q     <= start_p_next ? mant_t'(volt_acc - MANT_OFFSET) : '0;
			volt_exp_out_q <= start_p_next ? volt_exp_next : '0;
			curr_val_q     <= start_p_next ? mant_t'(curr_acc - MANT_OFFSET) : '0;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.line_ok          = line_ok_q;
	assign results.time_value       = time_val_q;
	assign results.time_exponent    = time_exp_out_q;
	assign results.voltage_value    = volt_val_q;
	assign results.voltage_exponent = volt_exp_out_q;
	assign results.current_value    = curr_val_q;

	// a line end restarts the position count
	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		line_end |=> pos_q == '0)
		else $error("position not cleared after line end");

	// position advances by one per character until it saturates
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !chars.last_of_line && pos_q != POS_MAX |=> pos_q == $past(pos_q) + POS_W'(1))
		else $error("position did not advance");

	// a held word blocks new characters
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !results.ready |-> !chars.ready)
		else $error("character accepted over a held word");

	// an invalid line carries zero fields
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !line_ok_q |-> time_val_q == '0 && volt_val_q == '0 &&
			curr_val_q == '0 && time_exp_out_q == '0 && volt_exp_out_q == '0)
		else $error("invalid line with nonzero fields");

	// each line end produces a word in the next cycle
	a_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		line_end |=> out_valid_q)
		else $error("line end without result word");

endmodule
`default_nettype wire
